[src/lz4d_pkg.sv]
// Package for the LZ4 block decompressor: parser phases, codes and transaction types.
// No dependencies.
package lz4d_pkg;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TRUNC     = 3'd1;
    localparam logic [2:0] ERR_LIT_OVR   = 3'd2;
    localparam logic [2:0] ERR_OFFSET    = 3'd3;
    localparam logic [2:0] ERR_MATCH_OVR = 3'd4;
    localparam logic [2:0] ERR_BYTE_MATCH = 3'd5;

    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    typedef enum logic [2:0] {
        PH_TOKEN, PH_LITEXT, PH_LIT, PH_OFFLO, PH_OFFHI, PH_MEXT, PH_DISCARD
    } t_phase;

    // Back part states.
    typedef enum logic [1:0] {
        BK_IDLE, BK_READ, BK_COPY
    } t_bstate;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] block_status;
        logic [2:0] error_code;
        logic [31:0] bytes_produced;
        logic       match_pending;
        logic       last_of_run;
    } t_result;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
        logic       end_of_block;
    } t_item;

endpackage

[src/lz4d_if.sv]
// Valid/ready stream interface carrying one transaction of type T.
// No dependencies; the payload type is a parameter.
interface lz4d_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/lz4d_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module lz4d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

[src/lz4d_queue.sv]
// Two-entry queue of input transactions between the front and back parts.
// Depends on lz4d_pkg and lz4d_if.
module lz4d_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    lz4d_if.sink   s_in,
    lz4d_if.source m_out
);
    import lz4d_pkg::*;

    lz4d_pkg::t_item r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       w_push, w_pop;

    assign s_in.ready  = (r_cnt != 2'd2);
    assign m_out.valid = (r_cnt != 2'd0);
    assign m_out.data  = r_q[r_rd];
    assign w_push = s_in.valid && s_in.ready;
    assign w_pop  = m_out.valid && m_out.ready;

    // Occupancy and read pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    // Write at the slot after the occupied ones.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_rd ^ r_cnt[0]] <= s_in.data;
        end
    end
endmodule

[src/lz4d_engine.sv]
// Back part: parser, counters, error tracking and match copy through the history RAM.
// Depends on lz4d_pkg, lz4d_if and lz4d_ram.
module lz4d_engine #(
    parameter int WINDOW_BYTES = 65536,
    parameter int BYTES_PER_TICK = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_capacity,
    lz4d_if.sink        s_item,
    lz4d_if.source      m_res
);
    import lz4d_pkg::*;

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam int TW = $clog2(BYTES_PER_TICK + 1);

    t_phase  r_phase, n_phase;
    t_bstate r_bst, n_bst;
    logic [31:0] r_lit, n_lit, r_mrem, n_mrem, r_prod, n_prod;
    logic [3:0]  r_nib, n_nib;
    logic [15:0] r_off, n_off;
    logic [2:0]  r_err, n_err;
    logic [TW-1:0] r_n, n_n;
    logic        r_ov, n_ov;
    t_result     r_res, n_res;

    logic        w_take, w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [7:0]  w_wdata, w_rdata;
    logic [32:0] w_sum;
    logic [32:0] w_need;
    t_item       w_it;

    assign w_it = s_item.data;
    assign m_res.valid = r_ov;
    assign m_res.data  = r_res;

    lz4d_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    // Copy source address: counts along with the producer, offset behind it.
    assign w_raddr = AW'(r_prod - {16'd0, r_off});
    assign w_waddr = AW'(r_prod);

    // Next state of the sequencer.
    always_comb begin
        n_bst = r_bst;
        unique case (r_bst)
            BK_IDLE: if (s_item.valid && s_item.ready && w_it.opcode == OP_TICK
                         && r_phase == PH_TOKEN && r_mrem != 32'd0) begin
                n_bst = BK_READ;
            end
            BK_READ: n_bst = BK_COPY;
            BK_COPY: if (!r_ov || m_res.ready) begin
                n_bst = (r_mrem == 32'd1 || r_n == TW'(BYTES_PER_TICK - 1))
                        ? BK_IDLE : BK_READ;
            end
            default: n_bst = BK_IDLE;
        endcase
    end

    // Datapath and result formation.
    always_comb begin
        n_phase = r_phase; n_lit = r_lit; n_mrem = r_mrem; n_prod = r_prod;
        n_nib = r_nib; n_off = r_off; n_err = r_err; n_n = r_n;
        n_ov = r_ov && !m_res.ready; n_res = r_res;
        w_we = 1'b0; w_wdata = w_it.data_byte;
        w_sum = 33'd0; w_need = 33'd0;
        w_take = 1'b0;
        s_item.ready = (r_bst == BK_IDLE) && (!r_ov || m_res.ready);
        if (r_bst == BK_COPY && (!r_ov || m_res.ready)) begin
            w_we = 1'b1; w_wdata = w_rdata;
            n_prod = r_prod + 32'd1; n_mrem = r_mrem - 32'd1; n_n = r_n + TW'(1);
            n_ov = 1'b1;
            n_res = '{w_rdata, 1'b1, ST_BUSY, ERR_NONE, r_prod + 32'd1,
                      r_mrem != 32'd1, n_bst == BK_IDLE};
        end
        if (s_item.valid && s_item.ready) begin
            w_take = 1'b1;
            n_ov = 1'b1;
            n_n = '0;
            if (w_it.opcode == OP_TICK) begin
                n_res = '{8'd0, 1'b0, r_phase == PH_DISCARD ? ST_FAIL : ST_BUSY,
                          r_phase == PH_DISCARD ? r_err : ERR_NONE, r_prod,
                          r_phase == PH_TOKEN && r_mrem != 32'd0, 1'b1};
                if (r_phase == PH_TOKEN && r_mrem != 32'd0) begin
                    n_ov = r_ov && !m_res.ready;
                    n_res = r_res;
                end
            end else begin
                n_res = '{8'd0, 1'b0, ST_BUSY, ERR_NONE, 32'd0, 1'b0, 1'b1};
                unique case (r_phase)
                    PH_TOKEN: begin
                        if (r_mrem != 32'd0) begin
                            n_err = ERR_BYTE_MATCH; n_phase = PH_DISCARD;
                            n_lit = '0; n_mrem = '0;
                        end else begin
                            n_nib = w_it.data_byte[3:0];
                            if (w_it.data_byte[7:4] == 4'hf) begin
                                n_lit = 32'd15; n_phase = PH_LITEXT;
                            end else if (w_it.data_byte[7:4] != 4'h0) begin
                                w_need = {1'b0, r_prod} + 33'(w_it.data_byte[7:4]);
                                if (w_need > {1'b0, i_capacity}) begin
                                    n_err = ERR_LIT_OVR; n_phase = PH_DISCARD;
                                    n_lit = '0; n_mrem = '0;
                                end else begin
                                    n_lit = 32'(w_it.data_byte[7:4]);
                                    n_phase = PH_LIT;
                                end
                            end else begin
                                n_phase = PH_OFFLO;
                            end
                        end
                    end
                    PH_LITEXT: begin
                        w_sum = {1'b0, r_lit} + 33'(w_it.data_byte);
                        w_need = {1'b0, r_prod} + w_sum;
                        if (w_sum[32]) begin
                            n_err = ERR_LIT_OVR; n_phase = PH_DISCARD;
                            n_lit = '0; n_mrem = '0;
                        end else begin
                            n_lit = w_sum[31:0];
                            if (w_it.data_byte != 8'hff) begin
                                if (w_need > {1'b0, i_capacity}) begin
                                    n_err = ERR_LIT_OVR; n_phase = PH_DISCARD;
                                    n_lit = '0; n_mrem = '0;
                                end else begin
                                    n_phase = PH_LIT;
                                end
                            end
                        end
                    end
                    PH_LIT: begin
                        n_res.out_byte = w_it.data_byte; n_res.byte_valid = 1'b1;
                        w_we = 1'b1;
                        n_prod = r_prod + 32'd1; n_lit = r_lit - 32'd1;
                        if (r_lit == 32'd1) begin
                            n_phase = PH_OFFLO;
                        end
                    end
                    PH_OFFLO: begin
                        n_off = {8'd0, w_it.data_byte}; n_phase = PH_OFFHI;
                    end
                    PH_OFFHI: begin
                        n_off = {w_it.data_byte, r_off[7:0]};
                        w_need = {1'b0, r_prod} + 33'({r_nib} + 5'd4);
                        if (n_off == 16'd0 || {16'd0, n_off} > r_prod) begin
                            n_err = ERR_OFFSET; n_phase = PH_DISCARD;
                            n_lit = '0; n_mrem = '0;
                        end else if (r_nib == 4'hf) begin
                            n_mrem = 32'd15; n_phase = PH_MEXT;
                        end else if (w_need > {1'b0, i_capacity}) begin
                            n_err = ERR_MATCH_OVR; n_phase = PH_DISCARD;
                            n_lit = '0; n_mrem = '0;
                        end else begin
                            n_mrem = 32'(r_nib) + 32'd4; n_phase = PH_TOKEN;
                        end
                    end
                    PH_MEXT: begin
                        w_sum = {1'b0, r_mrem} + 33'(w_it.data_byte)
                              + ((w_it.data_byte != 8'hff) ? 33'd4 : 33'd0);
                        w_need = {1'b0, r_prod} + w_sum;
                        if (w_sum[32]) begin
                            n_err = ERR_MATCH_OVR; n_phase = PH_DISCARD;
                            n_lit = '0; n_mrem = '0;
                        end else if (w_it.data_byte == 8'hff) begin
                            n_mrem = w_sum[31:0];
                        end else if (w_need > {1'b0, i_capacity}) begin
                            n_err = ERR_MATCH_OVR; n_phase = PH_DISCARD;
                            n_lit = '0; n_mrem = '0;
                        end else begin
                            n_mrem = w_sum[31:0]; n_phase = PH_TOKEN;
                        end
                    end
                    default: ;
                endcase
                n_res.bytes_produced = n_prod;
                if (w_it.end_of_block) begin
                    if (n_phase == PH_DISCARD) begin
                        n_res.block_status = ST_FAIL; n_res.error_code = n_err;
                    end else if (n_phase == PH_OFFLO) begin
                        n_res.block_status = ST_OK;
                    end else begin
                        n_res.block_status = ST_FAIL; n_res.error_code = ERR_TRUNC;
                    end
                    n_phase = PH_TOKEN; n_lit = '0; n_mrem = '0; n_nib = '0;
                    n_off = '0; n_prod = '0; n_err = ERR_NONE;
                end else if (n_phase == PH_DISCARD) begin
                    n_res.block_status = ST_FAIL; n_res.error_code = n_err;
                end
                n_res.match_pending = (n_phase == PH_TOKEN) && (n_mrem != 32'd0);
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TOKEN; r_bst <= BK_IDLE; r_lit <= '0; r_mrem <= '0;
            r_prod <= '0; r_nib <= '0; r_off <= '0; r_err <= ERR_NONE;
            r_n <= '0; r_ov <= 1'b0;
        end else begin
            r_phase <= n_phase; r_bst <= n_bst; r_lit <= n_lit; r_mrem <= n_mrem;
            r_prod <= n_prod; r_nib <= n_nib; r_off <= n_off; r_err <= n_err;
            r_n <= n_n; r_ov <= n_ov;
        end
    end

    // Result register needs no reset.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    a_copy_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> r_bst == BK_IDLE) else $error("item taken during copy");
    a_err_in_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DISCARD |-> r_err != ERR_NONE) else $error("discard without code");
    a_copy_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bst == BK_READ |-> r_mrem != 32'd0) else $error("copy with no match left");
endmodule

[src/lz4_block_decompressor.sv]
// Top level of the LZ4 block decompressor: input queue feeding the decode engine.
// Depends on lz4d_pkg, lz4d_if, lz4d_queue, lz4d_engine and lz4d_ram.
// One transaction per compressed byte or tick. A compressed byte or idle tick gives one
// result; a tick with a pending match gives up to BYTES_PER_TICK results, each copied byte
// passing through a read and a copy state for the registered read of the history RAM.
// A two-entry queue decouples the input from the engine, and the result register lets the
// engine accept the next transaction in the same cycle that the waiting result is taken.
// The history RAM needs no clearing, so the block is ready right after reset.
module lz4_block_decompressor #(
    parameter int WINDOW_BYTES = 65536,
    parameter int BYTES_PER_TICK = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    lz4d_if.sink        s_in,
    lz4d_if.source      m_out
);
    import lz4d_pkg::*;

    logic [31:0] r_capacity;

    lz4d_if #(.T(lz4d_pkg::t_item)) q2e (i_clk);

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 32'd65536;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    lz4d_queue u_queue (.i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_in), .m_out(q2e));

    lz4d_engine #(.WINDOW_BYTES(WINDOW_BYTES), .BYTES_PER_TICK(BYTES_PER_TICK)) u_eng (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_capacity(r_capacity),
        .s_item(q2e), .m_res(m_out)
    );
endmodule

[dv/lz4d_checker.sv]
// Checker for the LZ4 block decompressor: watches both streams, predicts every result.
// Depends on lz4d_pkg for the transaction types and codes.
module lz4d_checker
    import lz4d_pkg::*;
#(
    parameter int WINDOW_BYTES = 65536,
    parameter int BYTES_PER_TICK = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_item       i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_result     i_out_data,
    output int          o_fail_count,
    output int          o_outstanding
);

    // Decoder state as the predictor sees it.
    logic [7:0]  history [WINDOW_BYTES];
    logic [31:0] capacity;
    logic [31:0] lit_left;
    logic [31:0] match_left;
    logic [31:0] produced;
    t_phase      phase;
    logic [3:0]  match_len_nib;
    logic [15:0] offset;
    logic [2:0]  sticky_err;
    t_result     expected_results [$];

    initial begin
        o_fail_count = 0;
        o_outstanding = 0;
    end

    function automatic logic match_waiting();
        return (phase == PH_TOKEN) && (match_left != 0);
    endfunction

    task automatic clear_block();
        phase = PH_TOKEN;
        lit_left = '0;
        match_left = '0;
        match_len_nib = '0;
        offset = '0;
        produced = '0;
        sticky_err = ERR_NONE;
    endtask

    task automatic raise_error(input logic [2:0] code);
        sticky_err = code;
        phase = PH_DISCARD;
        lit_left = '0;
        match_left = '0;
    endtask

    task automatic open_literals(input logic [31:0] len);
        if ({1'b0, produced} + {1'b0, len} > {1'b0, capacity}) begin
            raise_error(ERR_LIT_OVR);
        end else begin
            lit_left = len;
            phase = PH_LIT;
        end
    endtask

    task automatic open_match(input logic [31:0] len);
        if ({1'b0, produced} + {1'b0, len} > {1'b0, capacity}) begin
            raise_error(ERR_MATCH_OVR);
        end else begin
            match_left = len;
            phase = PH_TOKEN;
        end
    endtask

    // Works out every result one accepted transaction causes.
    task automatic decode_item(input t_item it);
        t_result     r;
        logic [32:0] sum;
        logic [7:0]  v;
        logic [15:0] src;
        int          n;
        r = '0;
        if (it.opcode == OP_TICK) begin
            if (match_waiting()) begin
                n = 0;
                while (n < BYTES_PER_TICK && match_left != 0) begin
                    src = produced[15:0] - offset;
                    v = history[src];
                    history[produced[15:0]] = v;
                    produced++;
                    match_left--;
                    r = '0;
                    r.out_byte = v;
                    r.byte_valid = 1'b1;
                    r.bytes_produced = produced;
                    r.match_pending = (match_left != 0);
                    r.last_of_run = (n == BYTES_PER_TICK - 1) || (match_left == 0);
                    expected_results.push_back(r);
                    n++;
                end
            end else begin
                if (phase == PH_DISCARD) begin
                    r.block_status = ST_FAIL;
                    r.error_code = sticky_err;
                end
                r.bytes_produced = produced;
                r.match_pending = match_waiting();
                r.last_of_run = 1'b1;
                expected_results.push_back(r);
            end
            return;
        end

        // Compressed byte: advance the parser.
        case (phase)
            PH_TOKEN: begin
                if (match_left != 0) begin
                    raise_error(ERR_BYTE_MATCH);
                end else begin
                    match_len_nib = it.data_byte[3:0];
                    if (it.data_byte[7:4] == 4'hf) begin
                        lit_left = 32'd15;
                        phase = PH_LITEXT;
                    end else if (it.data_byte[7:4] != 0) begin
                        open_literals({28'd0, it.data_byte[7:4]});
                    end else begin
                        phase = PH_OFFLO;
                    end
                end
            end
            PH_LITEXT: begin
                sum = {1'b0, lit_left} + it.data_byte;
                if (sum[32]) begin
                    raise_error(ERR_LIT_OVR);
                end else begin
                    lit_left = sum[31:0];
                    if (it.data_byte != 8'hff) open_literals(sum[31:0]);
                end
            end
            PH_LIT: begin
                r.out_byte = it.data_byte;
                r.byte_valid = 1'b1;
                history[produced[15:0]] = it.data_byte;
                produced++;
                lit_left--;
                if (lit_left == 0) phase = PH_OFFLO;
            end
            PH_OFFLO: begin
                offset = {8'd0, it.data_byte};
                phase = PH_OFFHI;
            end
            PH_OFFHI: begin
                offset[15:8] = it.data_byte;
                if (offset == 0 || {16'd0, offset} > produced) begin
                    raise_error(ERR_OFFSET);
                end else if (match_len_nib == 4'hf) begin
                    match_left = 32'd15;
                    phase = PH_MEXT;
                end else begin
                    open_match({28'd0, match_len_nib} + 32'd4);
                end
            end
            PH_MEXT: begin
                sum = {1'b0, match_left} + it.data_byte;
                if (it.data_byte != 8'hff) sum = sum + 33'd4;
                if (sum[32]) raise_error(ERR_MATCH_OVR);
                else if (it.data_byte == 8'hff) match_left = sum[31:0];
                else open_match(sum[31:0]);
            end
            default: ;
        endcase

        r.bytes_produced = produced;
        if (it.end_of_block) begin
            if (phase == PH_DISCARD) begin
                r.block_status = ST_FAIL;
                r.error_code = sticky_err;
            end else if (phase == PH_OFFLO) begin
                r.block_status = ST_OK;
            end else begin
                r.block_status = ST_FAIL;
                r.error_code = ERR_TRUNC;
            end
            clear_block();
        end else if (phase == PH_DISCARD) begin
            r.block_status = ST_FAIL;
            r.error_code = sticky_err;
        end
        r.match_pending = match_waiting();
        r.last_of_run = 1'b1;
        expected_results.push_back(r);
    endtask

    // Compares one accepted result with the oldest expectation, field by field.
    task automatic compare_result(input t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            o_fail_count++;
            return;
        end
        want = expected_results.pop_front();
        if (got.out_byte !== want.out_byte)
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
        if (got.byte_valid !== want.byte_valid)
            $display("%0t: byte_valid expected %b actual %b", $time,
                     want.byte_valid, got.byte_valid);
        if (got.block_status !== want.block_status)
            $display("%0t: block_status expected %0d actual %0d", $time,
                     want.block_status, got.block_status);
        if (got.error_code !== want.error_code)
            $display("%0t: error_code expected %0d actual %0d", $time,
                     want.error_code, got.error_code);
        if (got.bytes_produced !== want.bytes_produced)
            $display("%0t: bytes_produced expected %0d actual %0d", $time,
                     want.bytes_produced, got.bytes_produced);
        if (got.match_pending !== want.match_pending)
            $display("%0t: match_pending expected %b actual %b", $time,
                     want.match_pending, got.match_pending);
        if (got.last_of_run !== want.last_of_run)
            $display("%0t: last_of_run expected %b actual %b", $time,
                     want.last_of_run, got.last_of_run);
        if (got !== want) o_fail_count++;
    endtask

    // Sample both streams and the register port at every edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            capacity = 32'd65536;
            clear_block();
            expected_results.delete();
        end else begin
            if (i_cfg_we) capacity = i_cfg_wdata;
            if (i_in_valid && i_in_ready) decode_item(i_in_data);
            if (i_out_valid && i_out_ready) compare_result(i_out_data);
        end
        o_outstanding = expected_results.size();
    end

endmodule

[dv/lz4_block_decompressor_tb.sv]
// Testbench top for the LZ4 block decompressor: clock, reset, stimulus and verdict.
// Depends on lz4d_pkg, lz4d_if, lz4_block_decompressor and lz4d_checker.
module lz4_block_decompressor_tb;
    import lz4d_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 480;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    int          fail_count;
    int          outstanding;
    int          cycle_count = 0;
    int          items_sent = 0;
    int          gen_produced;
    bit          calm = 1'b0;
    bit          noisy = 1'b0;
    bit          held = 1'b0;

    lz4d_if #(.T(t_item))   in_if (i_clk);
    lz4d_if #(.T(t_result)) out_if (i_clk);

    lz4_block_decompressor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_in        (in_if),
        .m_out       (out_if)
    );

    lz4d_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (in_if.valid),
        .i_in_ready    (in_if.ready),
        .i_in_data     (in_if.data),
        .i_out_valid   (out_if.valid),
        .i_out_ready   (out_if.ready),
        .i_out_data    (out_if.data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL lz4_block_decompressor");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off, and none at the end.
    initial begin
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!calm && !held && cycle_count > 600) begin
                held = 1'b1;
                out_if.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Sends one transaction and waits until the block takes it.
    task automatic send_item(input logic op, input logic [7:0] b, input logic eob);
        t_item it;
        it.opcode = op;
        it.data_byte = b;
        it.end_of_block = eob;
        if (noisy && $urandom_range(0, 29) == 0) it = t_item'($urandom);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Sends a length extension: bytes of 255 and a closing remainder.
    task automatic send_extension(input int rest);
        while (rest >= 255) begin
            send_item(OP_BYTE, 8'hff, 1'b0);
            rest -= 255;
        end
        send_item(OP_BYTE, rest[7:0], 1'b0);
    endtask

    // Builds one well-formed block of nseq sequences with random content.
    task automatic send_block(input int nseq);
        int lit;
        int mlen;
        int off;
        int s;
        int k;
        logic [3:0] lnib;
        logic [3:0] mnib;
        gen_produced = 0;
        for (s = 0; s < nseq; s++) begin
            lit = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 14);
            if (s == nseq - 1) begin
                lnib = (lit >= 15) ? 4'hf : lit[3:0];
                send_item(OP_BYTE, {lnib, 4'($urandom)}, lit == 0);
                if (lit >= 15) send_extension(lit - 15);
                for (k = 0; k < lit; k++) send_item(OP_BYTE, 8'($urandom), k == lit - 1);
                return;
            end
            if (gen_produced == 0 && lit == 0) lit = $urandom_range(1, 14);
            mnib = 4'($urandom);
            mlen = (mnib == 4'hf) ? $urandom_range(19, 60) : mnib + 4;
            lnib = (lit >= 15) ? 4'hf : lit[3:0];
            send_item(OP_BYTE, {lnib, mnib}, 1'b0);
            if (lit >= 15) send_extension(lit - 15);
            for (k = 0; k < lit; k++) send_item(OP_BYTE, 8'($urandom), 1'b0);
            gen_produced += lit;
            off = $urandom_range(1, (gen_produced > 65535) ? 65535 : gen_produced);
            send_item(OP_BYTE, off[7:0], 1'b0);
            send_item(OP_BYTE, off[15:8], 1'b0);
            if (mnib == 4'hf) send_extension(mlen - 19);
            for (k = 0; k < (mlen + 7) / 8; k++) send_item(OP_TICK, 8'($urandom), 1'($urandom));
            if ($urandom_range(0, 5) == 0) send_item(OP_TICK, 8'($urandom), 1'b0);
            gen_produced += mlen;
        end
    endtask

    // Lets the block drain, then writes the capacity register.
    task automatic write_capacity(input logic [31:0] value);
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Stimulus: directed cases, then random blocks under several capacities.
    initial begin
        int base;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        in_if.valid <= 1'b0;
        in_if.data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty block, and an idle tick.
        send_item(OP_TICK, 8'hff, 1'b1);
        send_item(OP_BYTE, 8'h00, 1'b1);
        // Literal extension of zero, match nibble 15 with a 255 extension.
        send_item(OP_BYTE, 8'hff, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b0);
        for (int k = 0; k < 15; k++) send_item(OP_BYTE, 8'(k * 17), 1'b0);
        send_item(OP_BYTE, 8'h01, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'hff, 1'b0);
        send_item(OP_BYTE, 8'h01, 1'b0);
        // A byte while the match is pending, then a tick in discard.
        send_item(OP_BYTE, 8'h10, 1'b0);
        send_item(OP_TICK, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b1);
        // Offset of zero.
        send_item(OP_BYTE, 8'h10, 1'b0);
        send_item(OP_BYTE, 8'haa, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b1);
        // Offset past the bytes produced, and truncation inside literals.
        send_item(OP_BYTE, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'h05, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b1);
        send_item(OP_BYTE, 8'h20, 1'b0);
        send_item(OP_BYTE, 8'h55, 1'b1);

        // No room at all: the first literal run overflows and the rest of that block is discarded.
        write_capacity(32'd0);
        send_block(2);
        send_item(OP_BYTE, 8'h00, 1'b1);
        write_capacity(32'd20);
        for (int k = 0; k < 4; k++) send_block($urandom_range(1, 3));
        write_capacity(32'hffff_ffff);
        for (int k = 0; k < 4; k++) send_block($urandom_range(1, 4));

        // Random part: mostly clean blocks, some with corrupted transactions.
        write_capacity(32'd65536);
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            noisy = ($urandom_range(0, 3) == 0);
            calm = (items_sent - base > RANDOM_ITEMS * 85 / 100);
            send_block($urandom_range(1, 5));
            noisy = 1'b0;
            if ($urandom_range(0, 9) == 0) send_item(OP_BYTE, 8'($urandom), 1'b1);
        end
        in_if.valid <= 1'b0;
        calm = 1'b1;

        // Drain, then let the block settle.
        while (outstanding != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("PASS lz4_block_decompressor");
        end else begin
            $display("FAIL lz4_block_decompressor");
        end
        $finish;
    end

endmodule
